// ----- rtl/cds_pkg.sv -----
`default_nettype none

package cds_pkg;

  localparam int COUNTER_SLOTS = 3;
  localparam int SLOT_W        = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;

  localparam int VAL_W   = 64;
  localparam int HALF_W  = VAL_W / 2;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SEL_W   = 2;
  localparam int MASK_W  = 2;
  localparam int MSTEP_W = 3;
  localparam int DCNT_W  = $clog2(VAL_W);

  localparam logic [MSTEP_W-1:0] MSTEP_LAST = MSTEP_W'(4);
  localparam logic [DCNT_W-1:0]  DCNT_LAST  = DCNT_W'(VAL_W - 1);
  localparam logic [VAL_W-1:0]   ALL_ONES   = '1;

  // counter selectors
  localparam logic [SEL_W-1:0] SEL_CYCLES = SEL_W'(0);
  localparam logic [SEL_W-1:0] SEL_INSTR  = SEL_W'(1);
  localparam logic [SEL_W-1:0] SEL_BRANCH = SEL_W'(2);

  // available_mask bits
  localparam int AVAIL_BASE_BIT   = 0;
  localparam int AVAIL_BRANCH_BIT = 1;

  // configuration register indexes
  localparam logic [1:0] REG_COUNTERS_ON    = 2'd0;
  localparam logic [1:0] REG_AVAILABLE_MASK = 2'd1;
  localparam logic [1:0] REG_BRANCH_MISS_ON = 2'd2;

  typedef struct packed {
    logic              counters_on;
    logic [MASK_W-1:0] available_mask;
    logic              branch_miss_on;
  } cds_cfg_t;

  typedef enum logic [1:0] {
    MOP_DV = 2'd0,
    MOP_Q  = 2'd1,
    MOP_R  = 2'd2
  } mul_op_t;

  typedef enum logic {
    DOP_DV   = 1'b0,
    DOP_PROD = 1'b1
  } div_op_t;

  typedef enum logic [2:0] {
    RES_ZERO = 3'd0,
    RES_ONES = 3'd1,
    RES_QUO  = 3'd2,
    RES_ACC  = 3'd3,
    RES_SUM  = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     check;
    logic     mul_start;
    mul_op_t  mul_op;
    logic     div_start;
    div_op_t  div_op;
    logic     acc_load;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cds_cmd_t;

  typedef struct packed {
    logic go;
    logic mul_busy;
    logic div_busy;
    logic prod_fits;
  } cds_sts_t;

endpackage

`default_nettype wire

// ----- rtl/cds_ctrl.sv -----
`default_nettype none

module cds_ctrl
  import cds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  cds_sts_t sts,
  output cds_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_PLAN   = 10'b0000000100,
    S_MUL_A  = 10'b0000001000,
    S_DIV_A  = 10'b0000010000,
    S_DIV_Q  = 10'b0000100000,
    S_MUL_Q  = 10'b0001000000,
    S_MUL_R  = 10'b0010000000,
    S_DIV_F  = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_op     = MOP_DV;
    cmd.div_op     = DOP_DV;
    cmd.res_sel    = RES_ZERO;
    s_tready       = 1'b0;
    out_valid_next = out_valid && !m_tready;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_PLAN;
      end
      S_PLAN: begin
        if (sts.go) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MOP_DV;
          state_next    = S_MUL_A;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_next   = S_FINISH;
        end
      end
      S_MUL_A: begin
        if (!sts.mul_busy) begin
          cmd.div_start = 1'b1;
          if (sts.prod_fits) begin
            cmd.div_op = DOP_PROD;
            state_next = S_DIV_A;
          end else begin
            // product too wide: divide first
            cmd.div_op = DOP_DV;
            state_next = S_DIV_Q;
          end
        end
      end
      S_DIV_A: begin
        if (!sts.div_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_QUO;
          state_next   = S_FINISH;
        end
      end
      S_DIV_Q: begin
        if (!sts.div_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MOP_Q;
          state_next    = S_MUL_Q;
        end
      end
      S_MUL_Q: begin
        if (!sts.mul_busy) begin
          if (!sts.prod_fits) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ONES;
            state_next   = S_FINISH;
          end else begin
            cmd.acc_load  = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MOP_R;
            state_next    = S_MUL_R;
          end
        end
      end
      S_MUL_R: begin
        if (!sts.mul_busy) begin
          if (sts.prod_fits) begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DOP_PROD;
            state_next    = S_DIV_F;
          end else begin
            // drop the fractional term
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ACC;
            state_next   = S_FINISH;
          end
        end
      end
      S_DIV_F: begin
        if (!sts.div_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_SUM;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier started while busy");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && cmd.div_start))
    else $error("multiplier and divider started together");

  a_ready_units_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!sts.mul_busy && !sts.div_busy))
    else $error("input ready while arithmetic units busy");

  a_accept_checks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_CHECK))
    else $error("accepted transaction not checked");

endmodule

`default_nettype wire

// ----- rtl/cds_dp.sv -----
`default_nettype none

module cds_dp
  import cds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cds_cfg_t         cfg,
  input  cds_cmd_t         cmd,
  input  logic [SEL_W-1:0] counter_sel,
  input  logic             read_ok,
  input  logic [VAL_W-1:0] count_value,
  input  logic [VAL_W-1:0] time_enabled,
  input  logic [VAL_W-1:0] time_running,
  output cds_sts_t         sts,
  output logic [VAL_W-1:0] scaled_delta
);

  // captured sample
  logic [SEL_W-1:0] sel_q;
  logic             ok_q;
  logic [VAL_W-1:0] cv_q, ce_q, cr_q;

  // per-slot history
  logic [VAL_W-1:0]         prev_count   [COUNTER_SLOTS];
  logic [VAL_W-1:0]         prev_enabled [COUNTER_SLOTS];
  logic [VAL_W-1:0]         prev_running [COUNTER_SLOTS];
  logic [COUNTER_SLOTS-1:0] prev_valid;

  logic [SLOT_W-1:0] slot_idx;
  logic              slot_en;
  logic [VAL_W:0]    sub_v, sub_e, sub_r;
  logic              usable;

  logic [VAL_W-1:0] dv, de, dr;
  logic             go;

  // multiplier
  logic [VAL_W-1:0]   ma, ma_src;
  logic [MSTEP_W-1:0] mstep;
  logic               mul_busy;
  logic [HALF_W-1:0]  ma_part, mb_part;
  logic [VAL_W-1:0]   pp;
  logic [1:0]         pp_sh;
  logic [PROD_W-1:0]  pp_wide, prod;

  // divider
  logic [VAL_W-1:0]  dq, rem, dq_src;
  logic [DCNT_W-1:0] dcnt;
  logic              div_busy;
  logic [VAL_W:0]    div_shift;
  logic [VAL_W+1:0]  div_trial;
  logic              div_borrow;

  logic [VAL_W-1:0] acc, res;
  logic [VAL_W:0]   sum;

  assign slot_idx = SLOT_W'(sel_q);

  always_comb begin
    slot_en = 1'b0;
    if (cfg.counters_on && (int'(sel_q) < COUNTER_SLOTS)) begin
      case (sel_q) inside
        SEL_CYCLES, SEL_INSTR: slot_en = cfg.available_mask[AVAIL_BASE_BIT];
        SEL_BRANCH: slot_en = cfg.branch_miss_on && cfg.available_mask[AVAIL_BRANCH_BIT];
        default:    slot_en = 1'b0;
      endcase
    end
  end

  assign sub_v  = {1'b0, cv_q} - {1'b0, prev_count[slot_idx]};
  assign sub_e  = {1'b0, ce_q} - {1'b0, prev_enabled[slot_idx]};
  assign sub_r  = {1'b0, cr_q} - {1'b0, prev_running[slot_idx]};
  assign usable = slot_en && ok_q && prev_valid[slot_idx] &&
                  !sub_v[VAL_W] && !sub_e[VAL_W] && !sub_r[VAL_W];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel_q <= counter_sel;
      ok_q  <= read_ok;
      cv_q  <= count_value;
      ce_q  <= time_enabled;
      cr_q  <= time_running;
    end
    if (cmd.check) begin
      dv <= sub_v[VAL_W-1:0];
      de <= sub_e[VAL_W-1:0];
      dr <= sub_r[VAL_W-1:0];
      if (slot_en && ok_q) begin
        prev_count[slot_idx]   <= cv_q;
        prev_enabled[slot_idx] <= ce_q;
        prev_running[slot_idx] <= cr_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= '0;
      go         <= 1'b0;
    end else if (cmd.check) begin
      go <= usable && (sub_v[VAL_W-1:0] != '0) && (sub_e[VAL_W-1:0] != '0) &&
            (sub_r[VAL_W-1:0] != '0);
      if (slot_en) begin
        prev_valid[slot_idx] <= ok_q;
      end
    end
  end

  // 64x64 multiply as four 32x32 partial products, one per cycle
  always_comb begin
    case (cmd.mul_op)
      MOP_Q:   ma_src = dq;
      MOP_R:   ma_src = rem;
      default: ma_src = dv;
    endcase
    ma_part = mstep[1] ? ma[VAL_W-1:HALF_W] : ma[HALF_W-1:0];
    mb_part = mstep[0] ? de[VAL_W-1:HALF_W] : de[HALF_W-1:0];
    case (pp_sh)
      2'd0:    pp_wide = {{VAL_W{1'b0}}, pp};
      2'd1:    pp_wide = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
      default: pp_wide = {pp, {VAL_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mstep    <= '0;
    end else if (cmd.mul_start) begin
      mul_busy <= 1'b1;
      mstep    <= '0;
    end else if (mul_busy) begin
      mstep <= mstep + MSTEP_W'(1);
      if (mstep == MSTEP_LAST) begin
        mul_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma   <= ma_src;
      prod <= '0;
    end else if (mul_busy) begin
      if (mstep != MSTEP_LAST) begin
        pp    <= VAL_W'(ma_part) * VAL_W'(mb_part);
        pp_sh <= {1'b0, mstep[1]} + {1'b0, mstep[0]};
      end
      if (mstep != '0) begin
        prod <= prod + pp_wide;
      end
    end
  end

  // restoring radix-2 divider by dr, one quotient bit per cycle
  assign dq_src     = (cmd.div_op == DOP_PROD) ? prod[VAL_W-1:0] : dv;
  assign div_shift  = {rem, dq[VAL_W-1]};
  assign div_trial  = {1'b0, div_shift} - {2'b00, dr};
  assign div_borrow = div_trial[VAL_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      dcnt     <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      dcnt     <= '0;
    end else if (div_busy) begin
      dcnt <= dcnt + DCNT_W'(1);
      if (dcnt == DCNT_LAST) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq  <= dq_src;
      rem <= '0;
    end else if (div_busy) begin
      dq  <= {dq[VAL_W-2:0], !div_borrow};
      rem <= div_borrow ? div_shift[VAL_W-1:0] : div_trial[VAL_W-1:0];
    end
  end

  assign sum = {1'b0, acc} + {1'b0, dq};

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc <= prod[VAL_W-1:0];
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ONES: res <= ALL_ONES;
        RES_QUO:  res <= dq;
        RES_ACC:  res <= acc;
        RES_SUM:  res <= sum[VAL_W] ? ALL_ONES : sum[VAL_W-1:0];
        default:  res <= '0;
      endcase
    end
    if (cmd.out_load) begin
      scaled_delta <= res;
    end
  end

  assign sts.go        = go;
  assign sts.mul_busy  = mul_busy;
  assign sts.div_busy  = div_busy;
  assign sts.prod_fits = (prod[PROD_W-1:VAL_W] == '0);

endmodule

`default_nettype wire

// ----- rtl/counter_delta_scaler_top.sv -----
// Counter delta scaler.
// Input stream (s_*): one transaction per counter sample. s_tuser carries the
// counter selector and the read-ok flag; s_tdata carries the raw value,
// time-enabled and time-running. Output stream (m_*): one transaction per
// input, the multiplex-scaled increment since the previous sample of that
// counter, saturating at all ones.
// Configuration goes through the APB port: counters_on at 0x0,
// available_mask at 0x4, branch_miss_on at 0x8; pready is tied high and
// reads return the register value.
// One sample is processed at a time. A sample that is not usable or has a
// zero delta gets a zero result with no arithmetic; a scaled one takes a
// multiply and a division; when the product exceeds 64 bits it takes up to
// three multiplies and two divisions on the shared radix-2 divider. The next
// sample is accepted in the cycle after the result is moved into the output
// register.
// The output register holds a result while m_tready is low; the block can
// accept and work on the next sample meanwhile, then waits for that register.
// Reset clears the configuration and every counter's history mark.
`default_nettype none

module counter_delta_scaler_top
  import cds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [3*VAL_W-1:0]    s_tdata,  // count_value, time_enabled, time_running
  input  logic [SEL_W:0]        s_tuser,  // counter_sel, read_ok
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VAL_W-1:0]      m_tdata   // scaled_delta
);

  cds_cfg_t cfg;
  cds_cmd_t cmd;
  cds_sts_t sts;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_COUNTERS_ON:    cfg.counters_on    <= pwdata[0];
        REG_AVAILABLE_MASK: cfg.available_mask <= pwdata[MASK_W-1:0];
        REG_BRANCH_MISS_ON: cfg.branch_miss_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COUNTERS_ON:    prdata = 32'(cfg.counters_on);
      REG_AVAILABLE_MASK: prdata = 32'(cfg.available_mask);
      REG_BRANCH_MISS_ON: prdata = 32'(cfg.branch_miss_on);
      default:            prdata = '0;
    endcase
  end

  cds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cds_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .counter_sel  (s_tuser[SEL_W-1:0]),
    .read_ok      (s_tuser[SEL_W]),
    .count_value  (s_tdata[VAL_W-1:0]),
    .time_enabled (s_tdata[2*VAL_W-1:VAL_W]),
    .time_running (s_tdata[3*VAL_W-1:2*VAL_W]),
    .sts          (sts),
    .scaled_delta (m_tdata)
  );

endmodule

`default_nettype wire
